### design/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int CNT_W_DEF     = $clog2(DEPTH_DEF + 1);

    typedef enum logic [2:0] {
        OP_PUSH_REAR  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_CLEAR      = 3'd4
    } deq_op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } deq_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic fetch;
    } deq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_fetch;
    } deq_stat_t;

endpackage

### design/deq_in_if.sv
interface deq_in_if ();

    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [31:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);

endinterface

### design/deq_out_if.sv
interface deq_out_if
    import deq_pkg::*;
#(
    parameter int CNT_W = CNT_W_DEF
) ();

    logic               valid;
    logic               ready;
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic [CNT_W-1:0]   count;
    logic               is_empty;

    modport source (
        output valid, output popped_value, output status, output front_value,
        output rear_value, output count, output is_empty, input ready
    );
    modport sink (
        input valid, input popped_value, input status, input front_value,
        input rear_value, input count, input is_empty, output ready
    );

endinterface

### design/deq_ctrl.sv
module deq_ctrl
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  deq_stat_t stat,
    output deq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   load;

    always_comb
    begin
        cmd        = '0;
        load       = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // The operation runs only once the result register is free or is
                // being emptied in this cycle.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.exec   = 1'b1;
                    load       = !stat.need_fetch;
                    state_next = stat.need_fetch ? S_FETCH : S_IDLE;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                load       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTHESIS
    a_fetch_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> !rsp_valid_reg)
        else $error("result register busy while fetching");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) != S_IDLE))
        else $error("result raised without an executed operation");

    a_exec_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_EXEC))
        else $error("captured beat not followed by execution");
`endif

endmodule

### design/deq_dp.sv
module deq_dp
    import deq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  deq_cmd_t           cmd,
    output deq_stat_t          stat,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    output logic signed [31:0] popped_value,
    output logic [1:0]         status,
    output logic signed [31:0] front_value,
    output logic signed [31:0] rear_value,
    output logic [CNT_W-1:0]   count,
    output logic               is_empty
);

    localparam int IDX_W = $clog2(DEPTH);

    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(i + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(i - 1'b1);
    endfunction

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [2:0]           op_reg;
    logic [31:0]          value_reg;
    logic [IDX_W-1:0]     head_reg;
    logic [IDX_W-1:0]     head_next;
    logic [IDX_W-1:0]     tail_reg;
    logic [IDX_W-1:0]     tail_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [WORD_BITS-1:0] front_reg;
    logic [WORD_BITS-1:0] front_next;
    logic [WORD_BITS-1:0] rear_reg;
    logic [WORD_BITS-1:0] rear_next;
    logic [WORD_BITS-1:0] popped_reg;
    logic [WORD_BITS-1:0] popped_next;
    deq_status_t          status_reg;
    deq_status_t          status_next;

    logic                 mem_we;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;
    logic [63:0]          value_wide;
    logic [WORD_BITS-1:0] word_in;
    logic                 empty;
    logic                 full;
    logic [63:0]          popped_wide;
    logic [63:0]          front_wide;
    logic [63:0]          rear_wide;

    assign value_wide = {32'b0, value_reg};
    assign word_in    = value_wide[WORD_BITS-1:0];
    assign empty      = (count_reg == '0);
    assign full       = (count_reg == CNT_W'(DEPTH));

    // A pop that leaves words behind needs the new end word from memory.
    assign stat.need_fetch = ((op_reg == OP_POP_FRONT) || (op_reg == OP_POP_REAR))
                             && (count_reg > CNT_W'(1));

    // The slot read is the one that becomes the new front or rear after a pop.
    assign rd_addr = (op_reg == OP_POP_REAR) ? step_down(step_down(tail_reg))
                                             : step_up(head_reg);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        front_next  = front_reg;
        rear_next   = rear_reg;
        popped_next = '0;
        status_next = ST_DONE;
        mem_we      = 1'b0;
        wr_addr     = tail_reg;
        unique case (op_reg)
            OP_PUSH_REAR:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    tail_next  = step_up(tail_reg);
                    count_next = count_reg + 1'b1;
                    rear_next  = word_in;
                    if (empty)
                    begin
                        front_next = word_in;
                    end
                end
            end
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    wr_addr    = step_down(head_reg);
                    head_next  = step_down(head_reg);
                    count_next = count_reg + 1'b1;
                    front_next = word_in;
                    if (empty)
                    begin
                        rear_next = word_in;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_REAR:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    if (op_reg == OP_POP_FRONT)
                    begin
                        popped_next = front_reg;
                        head_next   = step_up(head_reg);
                    end
                    else
                    begin
                        popped_next = rear_reg;
                        tail_next   = step_down(tail_reg);
                    end
                    // The last word leaving puts both indices back at slot zero.
                    if (count_reg == CNT_W'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                end
            end
            OP_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            mem[wr_addr] <= word_in;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            value_reg <= value;
        end
        if (cmd.exec)
        begin
            front_reg  <= front_next;
            rear_reg   <= rear_next;
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
        else if (cmd.fetch)
        begin
            if (op_reg == OP_POP_FRONT)
            begin
                front_reg <= rd_data_reg;
            end
            else
            begin
                rear_reg <= rd_data_reg;
            end
        end
    end

    // The result fields come from state that only changes once the result is taken.
    assign popped_wide  = 64'(popped_reg);
    assign front_wide   = empty ? 64'd0 : 64'(front_reg);
    assign rear_wide    = empty ? 64'd0 : 64'(rear_reg);
    assign popped_value = popped_wide[31:0];
    assign front_value  = front_wide[31:0];
    assign rear_value   = rear_wide[31:0];
    assign status       = status_reg;
    assign count        = count_reg;
    assign is_empty     = empty;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_empty_indices: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> ((head_reg == '0) && (tail_reg == '0)))
        else $error("empty queue with indices away from slot zero");

    a_fetch_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |-> $past(cmd.exec))
        else $error("fetch without a preceding pop");

    a_fetch_only_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && stat.need_fetch) |=> (count_reg != '0))
        else $error("fetch requested for an emptied queue");
`endif

endmodule

### design/double_ended_queue_core.sv
// Channel  Dir  Fields
// req      in   operation[2:0], value[31:0]
// rsp      out  popped_value, status, front_value, rear_value, count[CNT_W-1:0], is_empty
//
// A beat on req is taken whenever the block is idle, even while a result waits on rsp.
// A req beat is captured, then executed once the result register is free or being emptied,
// and its result is registered onto rsp; a pop that leaves words behind also passes through
// a fetch state, which loads the registered read of the new front or rear word from the slot memory.
// A new beat on req is therefore taken only once the last one is through, fetch state included.
// A stalled rsp holds the next item in its capture register until the result is taken.
// Reset empties the queue at once; slot contents are not cleared.
module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    deq_in_if.sink    req,
    deq_out_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    deq_cmd_t  cmd;
    deq_stat_t stat;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    deq_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .CNT_W     (CNT_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .operation    (req.operation),
        .value        (req.value),
        .popped_value (rsp.popped_value),
        .status       (rsp.status),
        .front_value  (rsp.front_value),
        .rear_value   (rsp.rear_value),
        .count        (rsp.count),
        .is_empty     (rsp.is_empty)
    );

endmodule

### dv/tb_double_ended_queue_core.sv
`timescale 1ns / 100ps

module tb_double_ended_queue_core;
    import deq_pkg::*;

    localparam int          PTR_W           = $clog2(DEPTH_DEF);
    localparam int          IDLE_LIMIT      = 3000;
    localparam int          RANDOM_ITEMS    = 1560;
    localparam logic [2:0]  OP_UNUSED_FIRST = 3'(OP_CLEAR) + 3'd1;
    localparam logic [2:0]  OP_UNUSED_LAST  = 3'h7;
    localparam logic [31:0] WORD_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN        = 32'h8000_0000;
    localparam logic [31:0] WORD_ONES       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0]          popped;
        deq_status_t          status;
        logic [31:0]          front;
        logic [31:0]          rear;
        logic [CNT_W_DEF-1:0] count;
        logic                 empty;
    } deq_result_t;

    logic clk = 1'b0;
    logic rst_n;

    deq_in_if  req ();
    deq_out_if rsp ();

    double_ended_queue_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the queue contents.
    logic [31:0]          shadow_slots [DEPTH_DEF];
    logic [PTR_W-1:0]     shadow_head;
    logic [PTR_W-1:0]     shadow_tail;
    logic [CNT_W_DEF-1:0] shadow_fill;

    deq_result_t pending_results [$];
    int          mismatches;
    int          burst_left;
    bit          gaps_on;

    function automatic deq_result_t deque_step(logic [2:0] op, logic [31:0] word);
        deq_result_t res;
        res = '0;
        res.status = ST_DONE;
        case (op)
            OP_PUSH_REAR, OP_PUSH_FRONT:
            begin
                if (shadow_fill == CNT_W_DEF'(DEPTH_DEF))
                    res.status = ST_FULL;
                else if (op == OP_PUSH_REAR)
                begin
                    shadow_slots[shadow_tail] = word;
                    shadow_tail = shadow_tail + 1'b1;
                    shadow_fill = shadow_fill + 1'b1;
                end
                else
                begin
                    shadow_head = shadow_head - 1'b1;
                    shadow_slots[shadow_head] = word;
                    shadow_fill = shadow_fill + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_REAR:
            begin
                if (shadow_fill == '0)
                    res.status = ST_EMPTY;
                else
                begin
                    if (op == OP_POP_FRONT)
                    begin
                        res.popped = shadow_slots[shadow_head];
                        shadow_head = shadow_head + 1'b1;
                    end
                    else
                    begin
                        shadow_tail = shadow_tail - 1'b1;
                        res.popped = shadow_slots[shadow_tail];
                    end
                    shadow_fill = shadow_fill - 1'b1;
                    // Both indices snap back to slot zero when the last word leaves.
                    if (shadow_fill == '0)
                    begin
                        shadow_head = '0;
                        shadow_tail = '0;
                    end
                end
            end
            OP_CLEAR:
            begin
                shadow_head = '0;
                shadow_tail = '0;
                shadow_fill = '0;
            end
            default:
            begin
            end
        endcase
        if (shadow_fill != '0)
        begin
            res.front = shadow_slots[shadow_head];
            res.rear  = shadow_slots[shadow_tail - 1'b1];
        end
        res.count = shadow_fill;
        res.empty = (shadow_fill == '0);
        return res;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    // push_pct steers the queue toward full or toward empty.
    function automatic logic [2:0] pick_op(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return OP_CLEAR;
        if (r < 4)
            return 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
    endfunction

    task automatic send_beat(input logic [2:0] op, input logic [31:0] word);
        int gap;
        if (gaps_on && burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, 6);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        req.valid     <= 1'b1;
        req.operation <= op;
        req.value     <= word;
        do @(posedge clk); while (req.ready !== 1'b1);
        pending_results.push_back(deque_step(op, word));
    endtask

    // Drops valid and holds off until every outstanding result has been taken.
    task automatic wait_drained();
        req.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic test_directed();
        gaps_on = 1'b0;
        send_beat(OP_POP_FRONT, rand_word());
        send_beat(OP_POP_REAR, rand_word());
        send_beat(OP_PUSH_REAR, WORD_MAX);
        send_beat(OP_PUSH_FRONT, WORD_MIN);
        send_beat(OP_PUSH_REAR, '0);
        send_beat(OP_PUSH_FRONT, WORD_ONES);
        send_beat(OP_POP_REAR, rand_word());
        send_beat(OP_POP_FRONT, rand_word());
        for (logic [3:0] op = 4'(OP_UNUSED_FIRST); op <= 4'(OP_UNUSED_LAST); op++)
            send_beat(op[2:0], rand_word());
        send_beat(OP_POP_FRONT, rand_word());
        send_beat(OP_POP_REAR, rand_word());
        send_beat(OP_POP_REAR, rand_word());
        // Front push from an empty queue wraps the head below slot zero.
        send_beat(OP_PUSH_FRONT, 32'h1234_5678);
        send_beat(OP_PUSH_REAR, 32'hA5A5_A5A5);
        send_beat(OP_POP_FRONT, rand_word());
        send_beat(OP_POP_FRONT, rand_word());
        send_beat(OP_PUSH_REAR, 32'd1);
        send_beat(OP_PUSH_REAR, 32'd2);
        send_beat(OP_CLEAR, rand_word());
        send_beat(OP_POP_FRONT, rand_word());
        send_beat(OP_PUSH_FRONT, 32'h5AA5_5AA5);
        send_beat(OP_POP_REAR, rand_word());
    endtask

    task automatic test_full_boundary();
        gaps_on = 1'b1;
        for (int pass = 0; pass < 2; pass++)
        begin
            send_beat(OP_CLEAR, rand_word());
            for (int i = 0; i < DEPTH_DEF; i++)
                send_beat($urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT, rand_word());
            send_beat(OP_PUSH_REAR, rand_word());
            send_beat(OP_PUSH_FRONT, rand_word());
            for (int i = 0; i < DEPTH_DEF; i++)
                send_beat($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR, rand_word());
            send_beat(OP_POP_FRONT, rand_word());
        end
    endtask

    task automatic test_pressure_pause();
        gaps_on = 1'b0;
        for (int round = 0; round < 3; round++)
        begin
            for (int i = 0; i < 10; i++)
                send_beat(pick_op(60), rand_word());
            wait_drained();
        end
    endtask

    task automatic test_random();
        int push_pct;
        push_pct = 50;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 150 == 0)
                gaps_on = $urandom_range(0, 2) != 0;
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: push_pct = 80;
                    1: push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            send_beat(pick_op(push_pct), rand_word());
        end
    endtask

    initial
    begin
        mismatches    = 0;
        burst_left    = 0;
        gaps_on       = 1'b0;
        shadow_head   = '0;
        shadow_tail   = '0;
        shadow_fill   = '0;
        rst_n         <= 1'b0;
        req.valid     <= 1'b0;
        req.operation <= OP_PUSH_REAR;
        req.value     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_full_boundary();
        test_pressure_pause();
        test_random();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // The receiver cycles through stall patterns: always ready, light random
    // stalls, a regular rhythm from bit 2 of the cycle counter, and heavy random stalls.
    initial
    begin
        int cycle;
        int stall_mode;
        cycle      = 0;
        stall_mode = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= $urandom_range(0, 3) != 0;
                2: rsp.ready <= cycle[2];
                default: rsp.ready <= $urandom_range(0, 3) == 0;
            endcase
        end
    end

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        deq_result_t want;
        if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: unexpected result beat, status %0d count %0d",
                         $time, rsp.status, rsp.count);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("popped_value", want.popped, rsp.popped_value);
                check_field("status", 32'(want.status), 32'(rsp.status));
                check_field("front_value", want.front, rsp.front_value);
                check_field("rear_value", want.rear, rsp.rear_value);
                check_field("count", 32'(want.count), 32'(rsp.count));
                check_field("is_empty", 32'(want.empty), 32'(rsp.is_empty));
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid === 1'b1 && req.ready === 1'b1) ||
                (rsp.valid === 1'b1 && rsp.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t ns: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

endmodule
